// ===== hdl/failure_watchdog_reboot_cap_core_defines.svh =====
// ----------------------------------------------------------------------------
// Failure watchdog assertion macros
// Shorthands for the concurrent checks of the watchdog core.
// ----------------------------------------------------------------------------
`ifndef FAILURE_WATCHDOG_REBOOT_CAP_CORE_DEFINES_SVH
`define FAILURE_WATCHDOG_REBOOT_CAP_CORE_DEFINES_SVH

// Checks that a property holds at every rising edge of clk_i outside reset.
`define FWRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define FWRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fwrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Failure watchdog package
// Sizes, codes, reset values and helpers shared by the watchdog files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwrc_pkg;

  // Number of reboot timestamps kept in the history.
  localparam int unsigned HistDepth = 8;
  localparam int unsigned IdxW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned CntW      = $clog2(HistDepth + 1);

  localparam int unsigned ActionW   = 3;
  localparam int unsigned NowW      = 32;
  localparam int unsigned FailW     = 8;
  localparam int unsigned RecentW   = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MinutesW  = 16;
  localparam int unsigned WinW      = 22;

  typedef enum logic [ActionW-1:0] {
    ACT_CAMERA_OK    = 3'd0,
    ACT_CAMERA_FAIL  = 3'd1,
    ACT_UPLOAD_OK    = 3'd2,
    ACT_UPLOAD_FAIL  = 3'd3,
    ACT_WARM_RESTART = 3'd4,
    ACT_COLD_RESTART = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WDT_ENABLE   = 3'd0,
    CFG_CAMERA_LIMIT = 3'd1,
    CFG_UPLOAD_LIMIT = 3'd2,
    CFG_REBOOT_CAP   = 3'd3,
    CFG_WINDOW_MIN   = 3'd4
  } cfg_idx_e;

  // Fields of one result transfer.
  typedef struct packed {
    logic               reboot_request;
    logic               held_off;
    logic [FailW-1:0]   camera_fail_count;
    logic [FailW-1:0]   upload_fail_count;
    logic [RecentW-1:0] recent_reboots;
    logic               reboot_pending;
  } result_t;

  localparam logic [FailW-1:0]    DefaultLimit   = 8'd3;
  localparam logic [FailW-1:0]    FailSat        = 8'd255;
  localparam logic [MinutesW-1:0] ResetWinMin    = 16'd60;
  localparam logic [WinW-1:0]     SecPerMin      = 22'd60;
  localparam logic [WinW-1:0]     ShortestWindow = 22'd60;

  // Window length in seconds; a zero setting means one minute.
  function automatic logic [WinW-1:0] window_secs(input logic [MinutesW-1:0] minutes);
    logic [WinW-1:0] w;
    w = WinW'(minutes) * SecPerMin;
    return (w == '0) ? ShortestWindow : w;
  endfunction

  // A zero limit or cap setting means three.
  function automatic logic [FailW-1:0] eff_limit(input logic [FailW-1:0] raw);
    return (raw == '0) ? DefaultLimit : raw;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fwrc_if.sv =====
// ----------------------------------------------------------------------------
// Failure watchdog channels
// Valid/ready channels for watchdog events and watchdog results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fwrc_ev_if;
  logic                          valid;
  logic                          ready;
  logic [fwrc_pkg::ActionW-1:0]  action;
  logic [fwrc_pkg::NowW-1:0]     now_seconds;

  modport source (output valid, output action, output now_seconds, input ready);
  modport sink   (input valid, input action, input now_seconds, output ready);
endinterface

interface fwrc_res_if;
  logic                          valid;
  logic                          ready;
  logic                          reboot_request;
  logic                          held_off;
  logic [fwrc_pkg::FailW-1:0]    camera_fail_count;
  logic [fwrc_pkg::FailW-1:0]    upload_fail_count;
  logic [fwrc_pkg::RecentW-1:0]  recent_reboots;
  logic                          reboot_pending;

  modport source (output valid, output reboot_request, output held_off,
                  output camera_fail_count, output upload_fail_count,
                  output recent_reboots, output reboot_pending, input ready);
  modport sink   (input valid, input reboot_request, input held_off,
                  input camera_fail_count, input upload_fail_count,
                  input recent_reboots, input reboot_pending, output ready);
endinterface

`default_nettype wire

// ===== hdl/failure_watchdog_reboot_cap_core.sv =====
// ----------------------------------------------------------------------------
// Failure watchdog with reboot rate cap
// Counts camera and upload failures and grants rate-limited reboots.
// ----------------------------------------------------------------------------
// Every event transfer yields exactly one result transfer. The core takes one
// event per clock cycle without gaps while the result channel does not stall:
// an event is captured in an input register, evaluated against the watchdog
// state by combinational logic, and its result lands in an output register,
// from which it leaves on the result channel. The output register lets the
// next event be evaluated in the cycle in which the previous result leaves; a
// stalled result stalls the input register and then the event channel. The
// rate is set by the evaluation logic, whose longest path runs through the
// eight window comparators of the timestamp history, their popcount and the
// cap compare. Configuration writes take effect at once and belong in idle
// periods only.
`timescale 1ns / 1ps
`default_nettype none
`include "failure_watchdog_reboot_cap_core_defines.svh"

module failure_watchdog_reboot_cap_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fwrc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [fwrc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  fwrc_ev_if.sink                             ev_i,
  fwrc_res_if.source                          res_o
);

  localparam int unsigned Depth = fwrc_pkg::HistDepth;
  localparam int unsigned IdxW  = fwrc_pkg::IdxW;
  localparam int unsigned CntW  = fwrc_pkg::CntW;
  localparam int unsigned NowW  = fwrc_pkg::NowW;
  localparam int unsigned FailW = fwrc_pkg::FailW;
  localparam int unsigned WinW  = fwrc_pkg::WinW;

  // Configuration registers. The window is kept in seconds so that the
  // evaluation cycle needs no multiply.
  logic              wdt_enable_q;
  logic [FailW-1:0]  camera_limit_q;
  logic [FailW-1:0]  upload_limit_q;
  logic [FailW-1:0]  reboot_cap_q;
  logic [WinW-1:0]   window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdt_enable_q   <= 1'b1;
      camera_limit_q <= fwrc_pkg::DefaultLimit;
      upload_limit_q <= fwrc_pkg::DefaultLimit;
      reboot_cap_q   <= fwrc_pkg::DefaultLimit;
      window_q       <= fwrc_pkg::window_secs(fwrc_pkg::ResetWinMin);
    end else if (cfg_we_i) begin
      unique case (fwrc_pkg::cfg_idx_e'(cfg_idx_i))
        fwrc_pkg::CFG_WDT_ENABLE:   wdt_enable_q   <= cfg_wdata_i[0];
        fwrc_pkg::CFG_CAMERA_LIMIT: camera_limit_q <= cfg_wdata_i[FailW-1:0];
        fwrc_pkg::CFG_UPLOAD_LIMIT: upload_limit_q <= cfg_wdata_i[FailW-1:0];
        fwrc_pkg::CFG_REBOOT_CAP:   reboot_cap_q   <= cfg_wdata_i[FailW-1:0];
        fwrc_pkg::CFG_WINDOW_MIN:
          window_q <= fwrc_pkg::window_secs(cfg_wdata_i[fwrc_pkg::MinutesW-1:0]);
        default: ;
      endcase
    end
  end

  // Input register and the handshake of the two stages.
  logic                              in_valid_q;
  logic [fwrc_pkg::ActionW-1:0]      in_action_q;
  logic [NowW-1:0]                   in_now_q;
  logic                              out_valid_q;
  logic                              advance;

  // The evaluation stage moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign ev_i.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (ev_i.ready) begin
      in_valid_q <= ev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_i.valid && ev_i.ready) begin
      in_action_q <= ev_i.action;
      in_now_q    <= ev_i.now_seconds;
    end
  end

  // Watchdog state. The history is meaningful only below stamp_count_q, so a
  // zero count also stands for an invalid history.
  logic [FailW-1:0]  cam_fail_q, cam_fail_d;
  logic [FailW-1:0]  upl_fail_q, upl_fail_d;
  logic              latched_q, latched_d;
  logic              hold_q, hold_d;
  logic [CntW-1:0]   stamp_count_q, stamp_count_d;
  logic [NowW-1:0]   hist_q [Depth];
  logic [NowW-1:0]   hist_d [Depth];

  // Window check of every stored timestamp against the event's time. A
  // timestamp in the future counts as stale.
  logic [Depth-1:0]  fresh;
  logic [CntW-1:0]   fresh_cnt;
  logic [CntW-1:0]   pos [Depth];

  always_comb begin
    fresh_cnt = '0;
    for (int i = 0; i < Depth; i++) begin
      pos[i]   = fresh_cnt;
      fresh[i] = (CntW'(i) < stamp_count_q) && (in_now_q >= hist_q[i]) &&
                 ((in_now_q - hist_q[i]) < NowW'(window_q));
      fresh_cnt = fresh_cnt + CntW'(fresh[i]);
    end
  end

  // Compaction of the fresh timestamps toward index zero, then the append of
  // the event's time. A full history loses its oldest entry first.
  logic [NowW-1:0]   kept [Depth];
  logic              hist_full;

  assign hist_full = (fresh_cnt == CntW'(Depth));

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      kept[j] = '0;
    end
    for (int i = 0; i < Depth; i++) begin
      if (fresh[i]) begin
        kept[pos[i][IdxW-1:0]] = hist_q[i];
      end
    end
    for (int j = 0; j < Depth; j++) begin
      hist_d[j] = kept[j];
    end
    if (hist_full) begin
      for (int j = 0; j < Depth - 1; j++) begin
        hist_d[j] = hist_q[j + 1];
      end
      hist_d[Depth-1] = in_now_q;
    end else begin
      hist_d[fresh_cnt[IdxW-1:0]] = in_now_q;
    end
  end

  // Event evaluation.
  logic [FailW-1:0]  cam_inc;
  logic [FailW-1:0]  upl_inc;
  logic              try_reboot;
  logic              grant;
  logic              hist_clear;
  logic [CntW-1:0]   recent;

  assign cam_inc = (cam_fail_q == fwrc_pkg::FailSat) ? cam_fail_q : cam_fail_q + 1'b1;
  assign upl_inc = (upl_fail_q == fwrc_pkg::FailSat) ? upl_fail_q : upl_fail_q + 1'b1;

  always_comb begin
    cam_fail_d = cam_fail_q;
    upl_fail_d = upl_fail_q;
    latched_d  = latched_q;
    hold_d     = hold_q;
    try_reboot = 1'b0;
    hist_clear = 1'b0;
    grant      = 1'b0;

    unique case (in_action_q) inside
      fwrc_pkg::ACT_CAMERA_OK: begin
        cam_fail_d = '0;
      end
      fwrc_pkg::ACT_CAMERA_FAIL: begin
        cam_fail_d = cam_inc;
        try_reboot = (cam_inc >= fwrc_pkg::eff_limit(camera_limit_q));
      end
      fwrc_pkg::ACT_UPLOAD_OK: begin
        upl_fail_d = '0;
      end
      fwrc_pkg::ACT_UPLOAD_FAIL: begin
        upl_fail_d = upl_inc;
        try_reboot = (upl_inc >= fwrc_pkg::eff_limit(upload_limit_q));
      end
      fwrc_pkg::ACT_WARM_RESTART, fwrc_pkg::ACT_COLD_RESTART: begin
        cam_fail_d = '0;
        upl_fail_d = '0;
        latched_d  = 1'b0;
        hold_d     = 1'b0;
        hist_clear = (in_action_q == fwrc_pkg::ACT_COLD_RESTART);
      end
      default: ;
    endcase

    // A reboot attempt is ignored while disabled or already latched;
    // otherwise the cap either holds it off or grants it.
    if (try_reboot && wdt_enable_q && !latched_q) begin
      if (FailW'(fresh_cnt) >= fwrc_pkg::eff_limit(reboot_cap_q)) begin
        hold_d = 1'b1;
      end else begin
        hold_d    = 1'b0;
        latched_d = 1'b1;
        grant     = 1'b1;
      end
    end

    // New history length. After a grant it is also the count of fresh timestamps,
    // since the appended time is always inside the window.
    if (hist_clear) begin
      stamp_count_d = '0;
    end else if (grant) begin
      stamp_count_d = hist_full ? fresh_cnt : fresh_cnt + 1'b1;
    end else begin
      stamp_count_d = stamp_count_q;
    end
    recent = (grant || hist_clear) ? stamp_count_d : fresh_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_fail_q    <= '0;
      upl_fail_q    <= '0;
      latched_q     <= 1'b0;
      hold_q        <= 1'b0;
      stamp_count_q <= '0;
    end else if (advance) begin
      cam_fail_q    <= cam_fail_d;
      upl_fail_q    <= upl_fail_d;
      latched_q     <= latched_d;
      hold_q        <= hold_d;
      stamp_count_q <= stamp_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && grant) begin
      hist_q <= hist_d;
    end
  end

  // Output register.
  fwrc_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.reboot_request    <= grant;
      res_q.held_off          <= hold_d;
      res_q.camera_fail_count <= cam_fail_d;
      res_q.upload_fail_count <= upl_fail_d;
      res_q.recent_reboots    <= fwrc_pkg::RecentW'(recent);
      res_q.reboot_pending    <= latched_d;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.reboot_request    = res_q.reboot_request;
  assign res_o.held_off          = res_q.held_off;
  assign res_o.camera_fail_count = res_q.camera_fail_count;
  assign res_o.upload_fail_count = res_q.upload_fail_count;
  assign res_o.recent_reboots    = res_q.recent_reboots;
  assign res_o.reboot_pending    = res_q.reboot_pending;

  // The history never grows beyond its storage.
  `FWRC_ASSERT(a_count_bounded, stamp_count_q <= CntW'(Depth), "history count exceeds depth")
  // A granted reboot is latched for the following events.
  `FWRC_ASSERT_NEXT(a_grant_latches, advance && grant, latched_q && (stamp_count_q != '0), "granted reboot not latched")
  // A grant and a hold-off never come from the same event.
  `FWRC_ASSERT(a_grant_not_held, !(out_valid_q && res_q.reboot_request && res_q.held_off), "grant reported as held off")
  // A waiting event keeps its place until the output side frees up.
  `FWRC_ASSERT_NEXT(a_stall_holds, in_valid_q && !advance, in_valid_q && $stable(in_now_q) && $stable(in_action_q), "stalled event lost")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Failure watchdog core testbench
// Drives watchdog events through the event channel and checks every result
// transfer against a cycle-free model of the counters, the reboot latch and
// the rate-capped timestamp history kept inside this file.
// ----------------------------------------------------------------------------

module testbench;
  import fwrc_pkg::*;

  // Action codes outside the enum; the core must treat them as no-ops that
  // still produce a result.
  localparam logic [ActionW-1:0] ActSpareLo    = 3'd6;
  localparam logic [ActionW-1:0] ActSpareHi    = 3'd7;
  // First register index that has no register behind it.
  localparam logic [CfgIdxW-1:0] CfgSpareFirst = 3'd5;

  // Cycles without an event transfer before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;
  // Cycles to keep watching after the last result.
  localparam int unsigned TailCycles = 8;
  // Mismatch reports are capped to keep the log readable.
  localparam int unsigned MaxReports = 40;

  typedef struct packed {
    logic               reboot_request;
    logic               held_off;
    logic [FailW-1:0]   camera_fail_count;
    logic [FailW-1:0]   upload_fail_count;
    logic [RecentW-1:0] recent_reboots;
    logic               reboot_pending;
  } wd_result_t;

  // One row of the directed table. Rows with typed set carry a result that is
  // obvious from the spec; all other rows are checked against the model.
  typedef struct {
    logic [ActionW-1:0] action;
    logic [NowW-1:0]    now_seconds;
    bit                 typed;
    wd_result_t         result;
  } event_row_t;

  localparam wd_result_t AllClear = '0;

  // --------------------------------------------------------------------------
  // Directed table. It walks the opening handful of reboots under the reset
  // settings: unused action codes, the first grant, latched requests, a
  // warm restart that keeps the history, the cap holding a reboot off,
  // timestamps that lie in the future of a smaller now_seconds, and a cold
  // restart that wipes everything.
  // --------------------------------------------------------------------------
  event_row_t event_table [0:25] = '{
    '{ACT_CAMERA_OK,    32'd0,          1'b1, AllClear},
    '{ActSpareLo,       32'hFFFF_FFFF,  1'b1, AllClear},
    '{ActSpareHi,       32'd0,          1'b1, AllClear},
    '{ACT_UPLOAD_OK,    32'd5,          1'b1, AllClear},
    '{ACT_CAMERA_FAIL,  32'd100,        1'b1, wd_result_t'{1'b0, 1'b0, 8'd1, 8'd0, 4'd0, 1'b0}},
    '{ACT_CAMERA_FAIL,  32'd100,        1'b1, wd_result_t'{1'b0, 1'b0, 8'd2, 8'd0, 4'd0, 1'b0}},
    // Third failure meets the reset limit: first grant, history holds one stamp.
    '{ACT_CAMERA_FAIL,  32'd100,        1'b1, wd_result_t'{1'b1, 1'b0, 8'd3, 8'd0, 4'd1, 1'b1}},
    // Reboot already latched, so further limits do nothing.
    '{ACT_CAMERA_FAIL,  32'd200,        1'b0, AllClear},
    '{ACT_UPLOAD_FAIL,  32'd200,        1'b0, AllClear},
    '{ACT_UPLOAD_FAIL,  32'd200,        1'b0, AllClear},
    '{ACT_UPLOAD_FAIL,  32'd200,        1'b0, AllClear},
    '{ACT_WARM_RESTART, 32'd300,        1'b0, AllClear},
    '{ACT_CAMERA_FAIL,  32'd400,        1'b0, AllClear},
    '{ACT_CAMERA_FAIL,  32'd400,        1'b0, AllClear},
    '{ACT_CAMERA_FAIL,  32'd400,        1'b0, AllClear},
    '{ACT_WARM_RESTART, 32'd500,        1'b0, AllClear},
    '{ACT_UPLOAD_FAIL,  32'd500,        1'b0, AllClear},
    '{ACT_UPLOAD_FAIL,  32'd500,        1'b0, AllClear},
    '{ACT_UPLOAD_FAIL,  32'd500,        1'b0, AllClear},
    '{ACT_WARM_RESTART, 32'd600,        1'b0, AllClear},
    '{ACT_CAMERA_FAIL,  32'd600,        1'b0, AllClear},
    '{ACT_CAMERA_FAIL,  32'd600,        1'b0, AllClear},
    // Three stamps inside the window: the cap holds this reboot off.
    '{ACT_CAMERA_FAIL,  32'd600,        1'b0, AllClear},
    // All stamps now lie after now_seconds, so none counts and a grant follows.
    '{ACT_CAMERA_FAIL,  32'd0,          1'b0, AllClear},
    '{ACT_COLD_RESTART, 32'hFFFF_FFFF,  1'b1, AllClear},
    '{ACT_UPLOAD_FAIL,  32'hFFFF_FFFF,  1'b0, AllClear}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and the signals that feed the core.
  // --------------------------------------------------------------------------
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;
  logic                sink_ready = 1'b0;

  // While set, neither the event sender nor the result receiver idles.
  bit steady = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fwrc_ev_if  ev_ch ();
  fwrc_res_if res_ch ();

  assign res_ch.ready = sink_ready;

  failure_watchdog_reboot_cap_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .ev_i        (ev_ch),
    .res_o       (res_ch)
  );

  // --------------------------------------------------------------------------
  // Watchdog model. It mirrors the register file and the state of the core
  // and is advanced once per accepted event, in transfer order.
  // --------------------------------------------------------------------------
  logic                cfg_enable    = 1'b1;
  logic [FailW-1:0]    cfg_cam_limit = 8'd3;
  logic [FailW-1:0]    cfg_up_limit  = 8'd3;
  logic [FailW-1:0]    cfg_cap       = 8'd3;
  logic [MinutesW-1:0] cfg_win_min   = 16'd60;

  logic [FailW-1:0] cam_fails = '0;
  logic [FailW-1:0] up_fails  = '0;
  logic             latched   = 1'b0;
  logic             holding   = 1'b0;
  logic             hist_ok   = 1'b0;
  logic [NowW-1:0]  stamps [HistDepth] = '{default: '0};
  int unsigned      stamp_n   = 0;

  // Bookkeeping for the summary and the verdict.
  int unsigned grants           = 0;
  int unsigned holdoffs         = 0;
  int unsigned events_sent      = 0;
  int unsigned results_seen     = 0;
  int unsigned settings_applied = 0;
  int unsigned mismatches       = 0;

  // Results still owed by the core, oldest first.
  wd_result_t awaited_results [$];

  // Free-running wall clock for the random part.
  logic [NowW-1:0] timeline = '0;

  // Cap window in seconds. The product fits easily in 32 bits.
  function automatic logic [NowW-1:0] window_len();
    logic [NowW-1:0] w;
    w = NowW'(cfg_win_min) * NowW'(SecPerMin);
    return (w == '0) ? NowW'(ShortestWindow) : w;
  endfunction

  // A stamp counts only if it is not in the future and younger than the window.
  function automatic bit stamp_is_recent(input logic [NowW-1:0] stamp,
                                         input logic [NowW-1:0] now,
                                         input logic [NowW-1:0] win);
    return (now >= stamp) && ((now - stamp) < win);
  endfunction

  function automatic int unsigned recent_stamps(input logic [NowW-1:0] now);
    int unsigned n;
    logic [NowW-1:0] win;
    n = 0;
    win = window_len();
    if (hist_ok) begin
      for (int i = 0; i < stamp_n; i++) begin
        if (stamp_is_recent(stamps[i], now, win)) n++;
      end
    end
    return n;
  endfunction

  // Applies the enable, latch and cap rules. On a grant the history is
  // compacted to its recent stamps, the oldest is dropped when it is full,
  // and now is appended.
  function automatic bit attempt_reboot(input logic [NowW-1:0] now);
    logic [NowW-1:0]  kept [HistDepth];
    int unsigned      kn;
    logic [NowW-1:0]  win;
    logic [FailW-1:0] cap;
    if (!cfg_enable || latched) return 1'b0;
    cap = (cfg_cap == '0) ? DefaultLimit : cfg_cap;
    if (recent_stamps(now) >= cap) begin
      holding = 1'b1;
      holdoffs++;
      return 1'b0;
    end
    holding = 1'b0;
    win = window_len();
    kn = 0;
    if (hist_ok) begin
      for (int i = 0; i < stamp_n; i++) begin
        if (stamp_is_recent(stamps[i], now, win)) begin
          kept[kn] = stamps[i];
          kn++;
        end
      end
    end
    if (kn >= HistDepth) begin
      for (int i = 0; i < HistDepth - 1; i++) kept[i] = kept[i + 1];
      kn = HistDepth - 1;
    end
    kept[kn] = now;
    kn++;
    for (int i = 0; i < HistDepth; i++) stamps[i] = (i < kn) ? kept[i] : '0;
    stamp_n = kn;
    hist_ok = 1'b1;
    latched = 1'b1;
    grants++;
    return 1'b1;
  endfunction

  // Advances the model by one event and returns the result the core owes.
  function automatic wd_result_t next_watchdog_result(input logic [ActionW-1:0] act,
                                                      input logic [NowW-1:0] now);
    bit         granted;
    wd_result_t r;
    granted = 1'b0;
    case (act) inside
      ACT_CAMERA_OK: cam_fails = '0;
      ACT_CAMERA_FAIL: begin
        if (cam_fails != FailSat) cam_fails++;
        if (cam_fails >= ((cfg_cam_limit == '0) ? DefaultLimit : cfg_cam_limit)) begin
          granted = attempt_reboot(now);
        end
      end
      ACT_UPLOAD_OK: up_fails = '0;
      ACT_UPLOAD_FAIL: begin
        if (up_fails != FailSat) up_fails++;
        if (up_fails >= ((cfg_up_limit == '0) ? DefaultLimit : cfg_up_limit)) begin
          granted = attempt_reboot(now);
        end
      end
      ACT_WARM_RESTART, ACT_COLD_RESTART: begin
        // Both restarts clear the volatile state; only a cold one forgets
        // the reboot history.
        cam_fails = '0;
        up_fails  = '0;
        latched   = 1'b0;
        holding   = 1'b0;
        if (act == ACT_COLD_RESTART) begin
          for (int i = 0; i < HistDepth; i++) stamps[i] = '0;
          stamp_n = 0;
          hist_ok = 1'b0;
        end
      end
      default: ;
    endcase
    r.reboot_request    = granted;
    r.held_off          = holding;
    r.camera_fail_count = cam_fails;
    r.upload_fail_count = up_fails;
    r.recent_reboots    = RecentW'(recent_stamps(now));
    r.reboot_pending    = latched;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Event sender. Called right after a rising edge; returns at the edge where
  // the transfer took place, so a following call keeps valid high without a
  // gap. Now and then, outside the steady stretch, it idles first.
  // --------------------------------------------------------------------------
  task automatic send_event(input logic [ActionW-1:0] act, input logic [NowW-1:0] now,
                            input bit typed, input wd_result_t typed_res);
    wd_result_t predicted;
    if (!steady && $urandom_range(0, 99) < 5) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    ev_ch.valid       <= 1'b1;
    ev_ch.action      <= act;
    ev_ch.now_seconds <= now;
    @(posedge clk_i);
    while (!ev_ch.ready) @(posedge clk_i);
    // The model advances on every accepted event, even when the expected
    // result was typed into the table.
    predicted = next_watchdog_result(act, now);
    awaited_results.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  task automatic post_event(input logic [ActionW-1:0] act, input logic [NowW-1:0] now);
    send_event(act, now, 1'b0, AllClear);
  endtask

  // Stops sending and waits until the core has delivered every result. Since
  // each event yields exactly one result, an empty queue means the core idles.
  task automatic drain_results();
    ev_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_WDT_ENABLE:   cfg_enable    = data[0];
      CFG_CAMERA_LIMIT: cfg_cam_limit = data[FailW-1:0];
      CFG_UPLOAD_LIMIT: cfg_up_limit  = data[FailW-1:0];
      CFG_REBOOT_CAP:   cfg_cap       = data[FailW-1:0];
      CFG_WINDOW_MIN:   cfg_win_min   = data[MinutesW-1:0];
      default: ;
    endcase
  endtask

  // Brings the core to idle and rewrites every register. A write to an index
  // with no register behind it is slipped in as well; it must change nothing.
  task automatic configure(input logic en, input logic [FailW-1:0] cam_lim,
                           input logic [FailW-1:0] up_lim, input logic [FailW-1:0] cap,
                           input logic [MinutesW-1:0] win_min);
    drain_results();
    write_reg(CFG_WDT_ENABLE, CfgDataW'(en));
    write_reg(CFG_CAMERA_LIMIT, CfgDataW'(cam_lim));
    write_reg(CfgSpareFirst + CfgIdxW'($urandom_range(0, 2)), CfgDataW'($urandom));
    write_reg(CFG_UPLOAD_LIMIT, CfgDataW'(up_lim));
    write_reg(CFG_REBOOT_CAP, CfgDataW'(cap));
    write_reg(CFG_WINDOW_MIN, CfgDataW'(win_min));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Most of it is failure bursts sized around the current
  // limit, separated by warm restarts, so that grants, latched requests and
  // cap hold-offs keep coming. The rest moves the wall clock around (large
  // steps, jumps backward that leave stamps in the future, values near the
  // top of the range) or sends raw noise with any action code. A burst is
  // cut short when the phase has sent its share of events.
  // --------------------------------------------------------------------------
  task automatic run_phase(input int unsigned n_items);
    int unsigned      start;
    int unsigned      burst;
    int unsigned      pick;
    logic [NowW-1:0]  win;
    logic [FailW-1:0] lim;
    bit               upload;
    start = events_sent;
    win = window_len();
    while (events_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        upload = $urandom_range(0, 1);
        lim = upload ? cfg_up_limit : cfg_cam_limit;
        if (lim == '0) lim = DefaultLimit;
        // One short of the limit up to a few past it, which also drives the
        // counters into saturation when the limit is 255.
        burst = lim - 1 + $urandom_range(0, 4);
        for (int k = 0; k < burst && events_sent - start < n_items; k++) begin
          post_event(upload ? ACT_UPLOAD_FAIL : ACT_CAMERA_FAIL, timeline);
          timeline += $urandom_range(0, win / 16);
        end
      end else if (pick < 75) begin
        post_event(ACT_WARM_RESTART, timeline);
        // Small steps pile stamps up inside the window; larger ones let
        // them age out.
        timeline += $urandom_range(0, 1) ? $urandom_range(0, win / 48)
                                         : $urandom_range(0, win / 3);
      end else if (pick < 82) begin
        post_event($urandom_range(0, 1) ? ACT_UPLOAD_OK : ACT_CAMERA_OK, timeline);
      end else if (pick < 85) begin
        post_event(ACT_COLD_RESTART, timeline);
      end else if (pick < 90) begin
        timeline += $urandom_range(win / 2, 2 * win);
      end else if (pick < 92) begin
        timeline = $urandom;
      end else if (pick < 94) begin
        timeline = 32'hFFFF_FFFF - $urandom_range(0, win);
      end else if (pick < 97) begin
        timeline -= $urandom_range(1, win);
      end else begin
        post_event(ActionW'($urandom_range(0, 7)), $urandom);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: ready drops in about one cycle of ten, except during
  // the steady stretch.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sink_ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  task automatic check_field(input string name, input logic [FailW-1:0] want,
                             input logic [FailW-1:0] got);
    if (got !== want) begin
      if (mismatches < MaxReports) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Every result transfer is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    wd_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("%0t ns: result transfer with nothing outstanding", $time);
        end
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("reboot_request", FailW'(want.reboot_request), FailW'(res_ch.reboot_request));
        check_field("held_off", FailW'(want.held_off), FailW'(res_ch.held_off));
        check_field("camera_fail_count", want.camera_fail_count, res_ch.camera_fail_count);
        check_field("upload_fail_count", want.upload_fail_count, res_ch.upload_fail_count);
        check_field("recent_reboots", FailW'(want.recent_reboots), FailW'(res_ch.recent_reboots));
        check_field("reboot_pending", FailW'(want.reboot_pending), FailW'(res_ch.reboot_pending));
      end
    end
  end

  // Hang detector: any stretch of QuietLimit cycles without an event transfer
  // ends the run.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ev_ch.valid && ev_ch.ready) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("%0t ns: no event transfer for %0d cycles, %0d results outstanding",
                 $time, QuietLimit, awaited_results.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned directed_count;
    ev_ch.valid       <= 1'b0;
    ev_ch.action      <= ACT_CAMERA_OK;
    ev_ch.now_seconds <= '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset values of the registers.
    for (int row = 0; row < $size(event_table); row++) begin
      send_event(event_table[row].action, event_table[row].now_seconds,
                 event_table[row].typed, event_table[row].result);
    end
    directed_count = events_sent;

    // Reset values written back explicitly.
    configure(1'b1, 8'd3, 8'd3, 8'd3, 16'd60);
    run_phase(150);

    // Zero settings stand for their defaults, and the window shrinks to 60 s.
    configure(1'b1, 8'd0, 8'd0, 8'd0, 16'd0);
    run_phase(150);

    // Every failure reboots, the cap never bites and the window is as wide
    // as it gets, so the history fills and drops its oldest stamp. This is
    // also the stretch where neither side idles.
    steady = 1'b1;
    configure(1'b1, 8'd1, 8'd1, 8'd255, 16'hFFFF);
    run_phase(150);
    steady = 1'b0;

    // A cap of one inside a one-minute window holds most reboots off.
    configure(1'b1, 8'd1, 8'd2, 8'd1, 16'd1);
    run_phase(120);

    // Watchdog disabled: limits are reached but nothing is requested, and
    // the hold flag keeps whatever it had.
    configure(1'b0, 8'd1, 8'd1, 8'd3, 16'd60);
    run_phase(80);

    // Largest limits: long failure runs that saturate the counters.
    configure(1'b1, 8'd255, 8'd255, 8'd2, 16'hFFFF);
    run_phase(270);

    // A few fully random settings.
    repeat (3) begin
      configure($urandom_range(0, 3) != 0, FailW'($urandom_range(0, 4)),
                FailW'($urandom_range(0, 4)), FailW'($urandom_range(0, 10)),
                $urandom_range(0, 1) ? MinutesW'($urandom_range(0, 3)) : MinutesW'($urandom));
      run_phase(60);
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d events (%0d from the directed table) under %0d register settings.",
             events_sent, directed_count, settings_applied);
    $display("Checked %0d results covering %0d reboot grants and %0d cap hold-offs.",
             results_seen, grants, holdoffs);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== failure_watchdog_reboot_cap_core.f =====
+incdir+hdl
hdl/fwrc_pkg.sv
hdl/fwrc_if.sv
hdl/failure_watchdog_reboot_cap_core.sv
tb/sv/testbench.sv
